// ===== hw/rtl/bnms_pkg.sv =====
// Package for the box non-maximum suppression unit.
// Holds the sequencer state type, default sizes and the compare-pipe result struct.
// No dependencies.
package bnms_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 11;
    localparam int SCORE_BITS     = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_I,
        ST_LATCH_I,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    // Result of the pairwise compare pipe, one entry per candidate suppressor.
    typedef struct packed {
        logic valid;   // a compare leaves the last stage this cycle
        logic hit;     // the candidate suppresses the box under test
        logic active;  // compares still inside the pipe
    } t_cmp_res;

endpackage

// ===== hw/rtl/bnms_iou_pipe.sv =====
// Three-stage pairwise suppression test: overlap, products, IoU threshold.
// Depends on bnms_pkg.
module bnms_iou_pipe
    import bnms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BOX_BITS   = 4 * COORD_BITS + SCORE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [BOX_BITS-1:0]     i_box_i,
    input  logic [BOX_BITS-1:0]     i_box_j,
    input  logic [2*COORD_BITS-1:0] i_area_i,
    output t_cmp_res                o_res
);

    localparam int C = COORD_BITS;

    logic [C-1:0]          xi, yi, wi, hi, xj, yj, wj, hj;
    logic [SCORE_BITS-1:0] si, sj;
    logic [C-1:0]          x1, y1;
    logic [C:0]            ex_i, ex_j, ey_i, ey_j, x2, y2;
    logic                  x_pos, y_pos;

    logic                  r_s2_v, r_s2_flag;
    logic [C-1:0]          r_s2_ow, r_s2_oh, r_s2_wj, r_s2_hj;
    logic                  r_s3_v, r_s3_flag;
    logic [2*C-1:0]        r_s3_inter, r_s3_aj;
    logic [2*C+1:0]        lhs, rhs;

    assign xi = i_box_i[C-1:0];
    assign yi = i_box_i[2*C-1:C];
    assign wi = i_box_i[3*C-1:2*C];
    assign hi = i_box_i[4*C-1:3*C];
    assign si = i_box_i[BOX_BITS-1:4*C];
    assign xj = i_box_j[C-1:0];
    assign yj = i_box_j[2*C-1:C];
    assign wj = i_box_j[3*C-1:2*C];
    assign hj = i_box_j[4*C-1:3*C];
    assign sj = i_box_j[BOX_BITS-1:4*C];

    always_comb begin
        ex_i  = {1'b0, xi} + {1'b0, wi};
        ex_j  = {1'b0, xj} + {1'b0, wj};
        ey_i  = {1'b0, yi} + {1'b0, hi};
        ey_j  = {1'b0, yj} + {1'b0, hj};
        x1    = (xi > xj) ? xi : xj;
        y1    = (yi > yj) ? yi : yj;
        x2    = (ex_j < ex_i) ? ex_j : ex_i;
        y2    = (ey_j < ey_i) ? ey_j : ey_i;
        x_pos = x2 > {1'b0, x1};
        y_pos = y2 > {1'b0, y1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s2_v <= i_valid;
            r_s3_v <= r_s2_v;
        end
        // overlap fits in C bits once positive: it never exceeds the smaller size
        r_s2_flag  <= (sj > si) && x_pos && y_pos;
        r_s2_ow    <= C'(x2 - {1'b0, x1});
        r_s2_oh    <= C'(y2 - {1'b0, y1});
        r_s2_wj    <= wj;
        r_s2_hj    <= hj;
        r_s3_flag  <= r_s2_flag;
        r_s3_inter <= (2*C)'(r_s2_ow) * (2*C)'(r_s2_oh);
        r_s3_aj    <= (2*C)'(r_s2_wj) * (2*C)'(r_s2_hj);
    end

    // IoU > 1/2  <=>  3*inter > area_i + area_j
    always_comb begin
        lhs = {1'b0, r_s3_inter, 1'b0} + {2'b00, r_s3_inter};
        rhs = {2'b00, i_area_i} + {2'b00, r_s3_aj};
        o_res.valid  = r_s3_v;
        o_res.hit    = r_s3_v && r_s3_flag && (lhs > rhs);
        o_res.active = r_s2_v || r_s3_v;
    end

endmodule

// ===== hw/rtl/box_non_maximum_suppression_unit.sv =====
// Top level of the box non-maximum suppression unit: box memory and sequencer.
// Depends on bnms_pkg and bnms_iou_pipe.
//
// Boxes load one per cycle while busy is low; a box that arrives with the store
// full is dropped and sets o_overflowed on every result of that list. The box
// marked final_box starts suppression: for N stored boxes, each box in turn goes
// through a read and a latch of the box under test, reads of all N stored boxes
// as candidate suppressors through the single read port of the box memory, a
// drain of the compare pipe and one emit step; a flush step ends the list.
// Survivors come out in load order, each on one o_kept_valid cycle; the receiver
// cannot stall. Survivors of a list are spaced by at least the test of one box,
// except the last one, which can follow the one before it on the next cycle.
module box_non_maximum_suppression_unit
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    input  logic [SCORE_BITS-1:0] i_score,
    input  logic                  i_final_box,
    output logic                  o_kept_valid,
    output logic [COORD_BITS-1:0] o_kept_x,
    output logic [COORD_BITS-1:0] o_kept_y,
    output logic [COORD_BITS-1:0] o_kept_width,
    output logic [COORD_BITS-1:0] o_kept_height,
    output logic [SCORE_BITS-1:0] o_kept_score,
    output logic                  o_final_kept,
    output logic                  o_overflowed
);

    localparam int C        = COORD_BITS;
    localparam int BOX_BITS = 4 * C + SCORE_BITS;
    localparam int AW       = $clog2(MAX_BOXES);
    localparam int CW       = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_BOXES);

    logic [BOX_BITS-1:0] box_store [MAX_BOXES];

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_drop, n_drop;
    logic [AW-1:0]       r_i, n_i, r_j, n_j, last_idx, rd_addr;
    logic                r_lost, n_lost;
    logic                r_pend_v, n_pend_v;
    logic                r_p1_v, n_p1_v;
    logic                r_out_v, n_out_v, n_out_final;
    logic                accept, wr_en, rd_en, latch_i, pend_load, out_load;
    logic [BOX_BITS-1:0] wr_data, r_rd_data, r_box_i, r_pend;
    logic [2*C-1:0]      r_area_i;
    logic                r_out_final, r_out_ovf;
    logic [BOX_BITS-1:0] r_out_box;
    t_cmp_res            cmp;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign wr_data  = {i_score, i_box_height, i_box_width, i_box_y, i_box_x};
    assign wr_en    = accept && (r_count < FULL);
    assign last_idx = AW'(r_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            box_store[r_count[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= box_store[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_lost      = r_lost || cmp.hit;
        n_pend_v    = r_pend_v;
        n_p1_v      = 1'b0;
        n_out_v     = 1'b0;
        n_out_final = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_i;
        latch_i     = 1'b0;
        pend_load   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_final_box) begin
                        n_i     = '0;
                        n_state = ST_READ_I;
                    end
                end
            end
            ST_READ_I: begin
                rd_en   = 1'b1;
                n_state = ST_LATCH_I;
            end
            ST_LATCH_I: begin
                latch_i = 1'b1;
                n_j     = '0;
                n_lost  = 1'b0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
                n_p1_v  = 1'b1;
                n_j     = r_j + 1'b1;
                if (r_j == last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_v && !cmp.active && !cmp.valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // a survivor is held back until we know whether it is the last one
                if (!r_lost) begin
                    pend_load = 1'b1;
                    n_pend_v  = 1'b1;
                    if (r_pend_v) begin
                        out_load = 1'b1;
                        n_out_v  = 1'b1;
                    end
                end
                if (r_i == last_idx) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_READ_I;
                end
            end
            ST_FLUSH: begin
                out_load    = 1'b1;
                n_out_v     = r_pend_v;
                n_out_final = 1'b1;
                n_pend_v    = 1'b0;
                n_count     = '0;
                n_drop      = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_lost   <= 1'b0;
            r_pend_v <= 1'b0;
            r_p1_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_i      <= n_i;
            r_j      <= n_j;
            r_lost   <= n_lost;
            r_pend_v <= n_pend_v;
            r_p1_v   <= n_p1_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch_i) begin
            r_box_i <= r_rd_data;
        end
        r_area_i <= (2*C)'(r_box_i[3*C-1:2*C]) * (2*C)'(r_box_i[4*C-1:3*C]);
        if (pend_load) begin
            r_pend <= r_box_i;
        end
        if (out_load) begin
            r_out_box   <= r_pend;
            r_out_final <= n_out_final;
            r_out_ovf   <= r_drop;
        end
    end

    bnms_iou_pipe #(
        .COORD_BITS (COORD_BITS),
        .BOX_BITS   (BOX_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_p1_v),
        .i_box_i  (r_box_i),
        .i_box_j  (r_rd_data),
        .i_area_i (r_area_i),
        .o_res    (cmp)
    );

    assign o_kept_valid  = r_out_v;
    assign o_kept_x      = r_out_box[C-1:0];
    assign o_kept_y      = r_out_box[2*C-1:C];
    assign o_kept_width  = r_out_box[3*C-1:2*C];
    assign o_kept_height = r_out_box[4*C-1:3*C];
    assign o_kept_score  = r_out_box[BOX_BITS-1:4*C];
    assign o_final_kept  = r_out_final;
    assign o_overflowed  = r_out_ovf;

endmodule

// ===== verif/testbench.sv =====
// Testbench for box_non_maximum_suppression_unit: directed lists, then random box lists.
// Survivors are checked against typed-in sets or an in-bench suppression predictor; depends on bnms_pkg.
// Self-checking, no external files.
module testbench
    import bnms_pkg::*;
();

    localparam int MAX_BOXES    = MAX_BOXES_DEF;
    localparam int CB           = COORD_BITS_DEF;
    localparam int RAND_BOXES   = 250;
    localparam int QUIET_FROM   = 200;      // no idling past this many random boxes
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 19;

    typedef struct packed {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [CB-1:0]         w;
        logic [CB-1:0]         h;
        logic [SCORE_BITS-1:0] s;
    } t_box;

    typedef struct packed {
        t_box kb;
        logic kfin;
        logic kovf;
    } t_kept;

    // one directed row: the box, its list mark, and whether the survivor set is typed in
    typedef struct packed {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [CB-1:0]         w;
        logic [CB-1:0]         h;
        logic [SCORE_BITS-1:0] s;
        logic                  fin;
        logic                  typed;
        logic                  keep;
    } t_dir_row;

    typedef enum int {
        MODE_SCATTER,
        MODE_CLUSTER,
        MODE_CLUSTER_TIES
    } t_list_mode;

    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        // lone all-zero box
        '{11'd0, 11'd0, 11'd0, 11'd0, 16'd0, 1'b1, 1'b1, 1'b1},
        // lone box at every maximum, edges run past the coordinate range
        '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 16'hFFFF, 1'b1, 1'b1, 1'b1},
        // identical boxes, higher score wins
        '{11'd100, 11'd100, 11'd50, 11'd50, 16'd1000, 1'b0, 1'b1, 1'b0},
        '{11'd100, 11'd100, 11'd50, 11'd50, 16'd2000, 1'b1, 1'b1, 1'b1},
        // identical boxes, equal scores: both stay
        '{11'd300, 11'd40, 11'd64, 11'd32, 16'd777, 1'b0, 1'b1, 1'b1},
        '{11'd300, 11'd40, 11'd64, 11'd32, 16'd777, 1'b1, 1'b1, 1'b1},
        // zero-width box never intersects
        '{11'd10, 11'd10, 11'd0, 11'd40, 16'd9000, 1'b0, 1'b1, 1'b1},
        '{11'd10, 11'd10, 11'd40, 11'd40, 16'd10, 1'b1, 1'b1, 1'b1},
        // edges touching, empty intersection
        '{11'd0, 11'd0, 11'd100, 11'd100, 16'd5, 1'b0, 1'b1, 1'b1},
        '{11'd100, 11'd0, 11'd100, 11'd100, 16'd60000, 1'b1, 1'b1, 1'b1},
        // IoU exactly one half: 3*1 == 2+1, not suppressed
        '{11'd0, 11'd0, 11'd2, 11'd1, 16'd500, 1'b0, 1'b1, 1'b1},
        '{11'd0, 11'd0, 11'd1, 11'd1, 16'd100, 1'b1, 1'b1, 1'b1},
        // just over one half: 3*2 > 2+3
        '{11'd0, 11'd0, 11'd2, 11'd1, 16'd100, 1'b0, 1'b1, 1'b0},
        '{11'd0, 11'd0, 11'd3, 11'd1, 16'd500, 1'b1, 1'b1, 1'b1},
        // chain: a suppressed box still suppresses the next one
        '{11'd0, 11'd0, 11'd10, 11'd10, 16'd300, 1'b0, 1'b0, 1'b0},
        '{11'd1, 11'd0, 11'd10, 11'd10, 16'd200, 1'b0, 1'b0, 1'b0},
        '{11'd4, 11'd0, 11'd10, 11'd10, 16'd100, 1'b1, 1'b0, 1'b0},
        // alternating bit patterns
        '{11'h555, 11'h2AA, 11'h555, 11'h2AA, 16'hAAAA, 1'b0, 1'b0, 1'b0},
        '{11'h2AA, 11'h555, 11'h2AA, 11'h555, 16'h5555, 1'b1, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [CB-1:0]         i_box_x;
    logic [CB-1:0]         i_box_y;
    logic [CB-1:0]         i_box_width;
    logic [CB-1:0]         i_box_height;
    logic [SCORE_BITS-1:0] i_score;
    logic                  i_final_box;
    logic                  o_kept_valid;
    logic [CB-1:0]         o_kept_x;
    logic [CB-1:0]         o_kept_y;
    logic [CB-1:0]         o_kept_width;
    logic [CB-1:0]         o_kept_height;
    logic [SCORE_BITS-1:0] o_kept_score;
    logic                  o_final_kept;
    logic                  o_overflowed;

    box_non_maximum_suppression_unit #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (CB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_box_x       (i_box_x),
        .i_box_y       (i_box_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_score       (i_score),
        .i_final_box   (i_final_box),
        .o_kept_valid  (o_kept_valid),
        .o_kept_x      (o_kept_x),
        .o_kept_y      (o_kept_y),
        .o_kept_width  (o_kept_width),
        .o_kept_height (o_kept_height),
        .o_kept_score  (o_kept_score),
        .o_final_kept  (o_final_kept),
        .o_overflowed  (o_overflowed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and expected survivors
    t_box  stored_boxes[$];
    bit    drop_seen;
    t_kept survivors[$];
    t_kept typed_kept[$];
    t_kept kept_q[$];

    int    err_cnt;
    int    cycle_cnt;
    int    boxes_sent;
    int    lists_done;
    int    kept_seen;
    int    overflow_lists;
    bit    idle_on;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    function automatic bit suppresses(input t_box j, input t_box i);
        logic [63:0] x1, y1, x2, y2, inter, ai, aj;
        if (j.s <= i.s) return 1'b0;
        x1 = (i.x > j.x) ? 64'(i.x) : 64'(j.x);
        y1 = (i.y > j.y) ? 64'(i.y) : 64'(j.y);
        x2 = 64'(i.x) + 64'(i.w);
        if (64'(j.x) + 64'(j.w) < x2) x2 = 64'(j.x) + 64'(j.w);
        y2 = 64'(i.y) + 64'(i.h);
        if (64'(j.y) + 64'(j.h) < y2) y2 = 64'(j.y) + 64'(j.h);
        if (x2 <= x1 || y2 <= y1) return 1'b0;
        inter = (x2 - x1) * (y2 - y1);
        ai    = 64'(i.w) * 64'(i.h);
        aj    = 64'(j.w) * 64'(j.h);
        return (3 * inter) > (ai + aj);
    endfunction

    // store or drop one box; on the list mark, fill survivors and clear the list
    function automatic void take_box(input t_box b, input bit fin);
        bit lost;
        survivors.delete();
        if (stored_boxes.size() < MAX_BOXES) stored_boxes.insert(stored_boxes.size(), b);
        else drop_seen = 1'b1;
        if (!fin) return;
        foreach (stored_boxes[i]) begin
            lost = 1'b0;
            foreach (stored_boxes[j]) begin
                if (j != i && suppresses(stored_boxes[j], stored_boxes[i])) lost = 1'b1;
            end
            if (!lost)
                survivors.insert(survivors.size(),
                                 '{kb: stored_boxes[i], kfin: 1'b0, kovf: drop_seen});
        end
        if (survivors.size() > 0) survivors[survivors.size()-1].kfin = 1'b1;
        if (drop_seen) overflow_lists++;
        stored_boxes.delete();
        drop_seen = 1'b0;
    endfunction

    task automatic send_box(input t_box b, input bit fin, input bit typed, input bit keep);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_box_x      <= b.x;
        i_box_y      <= b.y;
        i_box_width  <= b.w;
        i_box_height <= b.h;
        i_score      <= b.s;
        i_final_box  <= fin;
        do @(posedge i_clk); while (busy !== 1'b0);
        take_box(b, fin);
        if (typed) begin
            if (keep) typed_kept.insert(typed_kept.size(), '{kb: b, kfin: 1'b0, kovf: 1'b0});
            if (fin) begin
                typed_kept[typed_kept.size()-1].kfin = 1'b1;
                foreach (typed_kept[k]) kept_q.insert(kept_q.size(), typed_kept[k]);
                typed_kept.delete();
            end
        end else if (fin) begin
            foreach (survivors[k]) kept_q.insert(kept_q.size(), survivors[k]);
        end
        if (fin) lists_done++;
    endtask

    function automatic t_box make_box(input t_list_mode mode, input t_box base);
        t_box b;
        if (mode == MODE_SCATTER) begin
            b.x = CB'($urandom_range(0, 2047));
            b.y = CB'($urandom_range(0, 2047));
            b.w = CB'($urandom_range(0, 2047));
            b.h = CB'($urandom_range(0, 2047));
            b.s = SCORE_BITS'($urandom_range(0, 65535));
        end else begin
            b.x = base.x + CB'($urandom_range(0, 6));
            b.y = base.y + CB'($urandom_range(0, 6));
            b.w = base.w + CB'($urandom_range(0, 6));
            b.h = base.h + CB'($urandom_range(0, 6));
            if (mode == MODE_CLUSTER_TIES) b.s = base.s + SCORE_BITS'($urandom_range(0, 2));
            else b.s = SCORE_BITS'($urandom_range(0, 65535));
            // occasional empty box inside a cluster
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) == 0) b.w = '0;
                else b.h = '0;
            end
        end
        return b;
    endfunction

    task automatic send_list(input int n);
        t_list_mode mode;
        t_box       base;
        bit         quiet;
        quiet     = ($urandom_range(0, 2) == 0);
        mode      = t_list_mode'($urandom_range(0, 2));
        base.x    = CB'($urandom_range(0, 2047));
        base.y    = CB'($urandom_range(0, 2047));
        base.w    = CB'($urandom_range(1, 400));
        base.h    = CB'($urandom_range(1, 400));
        base.s    = SCORE_BITS'($urandom_range(0, 65535));
        for (int k = 0; k < n; k++) begin
            idle_on = !quiet && (boxes_sent < QUIET_FROM);
            send_box(make_box(mode, base), k == n - 1, 1'b0, 1'b0);
            boxes_sent++;
        end
    endtask

    // result checker: the receiver cannot stall, every strobe is one survivor
    always @(posedge i_clk) begin
        t_kept want;
        if (i_rst_n === 1'b1 && o_kept_valid === 1'b1) begin
            kept_seen++;
            if (kept_q.size() == 0) begin
                report_mismatch("unexpected survivor, x", o_kept_x, 0);
            end else begin
                want = kept_q.pop_front();
                if (o_kept_x !== want.kb.x) report_mismatch("kept_x", o_kept_x, want.kb.x);
                if (o_kept_y !== want.kb.y) report_mismatch("kept_y", o_kept_y, want.kb.y);
                if (o_kept_width !== want.kb.w)
                    report_mismatch("kept_width", o_kept_width, want.kb.w);
                if (o_kept_height !== want.kb.h)
                    report_mismatch("kept_height", o_kept_height, want.kb.h);
                if (o_kept_score !== want.kb.s)
                    report_mismatch("kept_score", o_kept_score, want.kb.s);
                if (o_final_kept !== want.kfin)
                    report_mismatch("final_kept", o_final_kept, want.kfin);
                if (o_overflowed !== want.kovf)
                    report_mismatch("overflowed", o_overflowed, want.kovf);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d survivors outstanding",
                     cycle_cnt, kept_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        t_box     b;
        int       list_no;
        int       n;

        err_cnt        = 0;
        cycle_cnt      = 0;
        boxes_sent     = 0;
        lists_done     = 0;
        kept_seen      = 0;
        overflow_lists = 0;
        drop_seen      = 1'b0;
        idle_on        = 1'b1;
        list_no        = 0;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_box_x      <= '0;
        i_box_y      <= '0;
        i_box_width  <= '0;
        i_box_height <= '0;
        i_score      <= '0;
        i_final_box  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TBL[r];
            b   = '{x: row.x, y: row.y, w: row.w, h: row.h, s: row.s};
            send_box(b, row.fin, row.typed, row.keep);
        end

        // mostly short lists; one exactly full store, one that overflows with the
        // marked item itself dropped
        while (boxes_sent < RAND_BOXES) begin
            if (list_no == 2) n = MAX_BOXES;
            else if (list_no == 5) n = MAX_BOXES + 2;
            else if ($urandom_range(0, 9) == 0) n = $urandom_range(12, 24);
            else n = $urandom_range(1, 8);
            send_list(n);
            list_no++;
        end
        start <= 1'b0;

        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d lists (%0d random boxes), %0d survivors checked, %0d overflowed",
                 lists_done, boxes_sent, kept_seen, overflow_lists);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bnms_pkg.sv
hw/rtl/bnms_iou_pipe.sv
hw/rtl/box_non_maximum_suppression_unit.sv
verif/testbench.sv
